@@ rtl/bmd_pkg.sv @@
// Shared types, fixed-point constants and helper functions for the BLDC derivative step.
`default_nettype none
package bmd_pkg;

	// fixed-point format of every datapath value
	localparam int FRAC_BITS = 16;

	localparam longint ONE_Q = 64'sd1 <<< FRAC_BITS;
	localparam longint PI_Q = ((64'sd314 <<< FRAC_BITS) + 64'sd50) / 64'sd100;
	localparam longint TWO_PI_Q = 2 * PI_Q;
	localparam longint PI3_Q = ((64'sd314 <<< FRAC_BITS) + 64'sd150) / 64'sd300;
	localparam longint PI23_Q = ((64'sd628 <<< FRAC_BITS) + 64'sd150) / 64'sd300;
	localparam longint K6_Q = ((64'sd600 <<< FRAC_BITS) + 64'sd157) / 64'sd314;

	localparam logic signed [31:0] PI_S = 32'(PI_Q);
	localparam logic signed [31:0] NEG_PI_S = 32'(-PI_Q);
	localparam logic signed [63:0] HALF_Q = 64'sd1 <<< (FRAC_BITS - 1);

	// width of the back-EMF shape values, covers sixteen times one
	localparam int EW = FRAC_BITS + 5;

	// configuration port
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 31;
	localparam logic [CFG_AW-1:0] CFG_RS = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_INV3L = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_FLUX = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_POLES = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_INVJ = 3'd4;
	localparam logic [CFG_AW-1:0] CFG_FRIC = 3'd5;

	// smallest shift that lifts two pi above the whole input range
	function automatic int wrap_shift();
		int s;
		s = 0;
		for (int j = 39; j >= 0; j--) begin
			if ((TWO_PI_Q <<< j) >= ((64'sd1 <<< 31) + PI_Q)) begin
				s = j;
			end
		end
		return s;
	endfunction

	// angle wrap: one conditional subtract of two pi times a power of two per stage
	localparam int WRAP_STEPS = wrap_shift() + 1;
	localparam int WRAP_W = 34;
	localparam logic [WRAP_W-1:0] WRAP_ADD = WRAP_W'(PI_Q + (TWO_PI_Q <<< (WRAP_STEPS - 1)));

	function automatic logic [WRAP_W-1:0] wrap_sub(input int j);
		return WRAP_W'(TWO_PI_Q <<< j);
	endfunction

	// mid queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QA_W = 2;

	typedef struct packed {
		logic signed [31:0] current_a;
		logic signed [31:0] current_b;
		logic signed [31:0] current_c;
		logic signed [31:0] rotor_speed;
		logic signed [31:0] rotor_angle;
		logic signed [31:0] voltage_a;
		logic signed [31:0] voltage_b;
		logic signed [31:0] voltage_c;
		logic signed [31:0] load_torque;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] current_a_rate;
		logic signed [31:0] current_b_rate;
		logic signed [31:0] current_c_rate;
		logic signed [31:0] speed_rate;
		logic signed [31:0] angle_rate;
		logic signed [31:0] motor_torque;
		logic [2:0]         sector;
		logic signed [31:0] wrapped_angle;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		in_item_t            item;
		logic [2:0]          sector;
		logic signed [31:0]  wrapped_angle;
		logic signed [EW-1:0] e0;
		logic signed [EW-1:0] e1;
		logic signed [EW-1:0] e2;
	} cmd_t;

	typedef struct packed {
		logic [30:0] rs;
		logic [30:0] inv3l;
		logic [30:0] flux;
		logic [6:0]  poles;
		logic [30:0] invj;
		logic [30:0] fric;
	} cfg_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// round to nearest, ties toward plus infinity
	function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
		return (v + HALF_Q) >>> FRAC_BITS;
	endfunction

endpackage
`default_nettype wire

@@ rtl/bmd_cfg_regs.sv @@
// Configuration register file of the BLDC derivative step.
`default_nettype none
module bmd_cfg_regs import bmd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_AW-1:0] cfg_addr,
	input  wire logic [CFG_DW-1:0] cfg_wdata,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	assign cfg = cfg_q;

	// write one register, drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rs <= 31'(ONE_Q);
			cfg_q.inv3l <= 31'(ONE_Q);
			cfg_q.flux <= 31'(ONE_Q);
			cfg_q.poles <= 7'd4;
			cfg_q.invj <= 31'(ONE_Q);
			cfg_q.fric <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_RS: cfg_q.rs <= cfg_wdata;
				CFG_INV3L: cfg_q.inv3l <= cfg_wdata;
				CFG_FLUX: cfg_q.flux <= cfg_wdata;
				CFG_POLES: cfg_q.poles <= cfg_wdata[6:0];
				CFG_INVJ: cfg_q.invj <= cfg_wdata;
				CFG_FRIC: cfg_q.fric <= cfg_wdata;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/bmd_front.sv @@
// Front pipeline: wraps the rotor angle, picks the sector and forms back-EMF shapes.
`default_nettype none
module bmd_front import bmd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic      full,
	input  in_item_t  in_item,
	output logic      cmd_valid,
	input  wire logic cmd_ready,
	output cmd_t      cmd
);

	localparam logic signed [31:0] PI3_S = 32'(PI3_Q);
	localparam logic signed [31:0] PI23_S = 32'(PI23_Q);
	localparam logic signed [31:0] K6_S = 32'(K6_Q);
	localparam logic signed [EW-1:0] ONE_E = EW'(ONE_Q);
	localparam logic signed [EW-1:0] THREE_E = EW'(3 * ONE_Q);
	localparam logic signed [EW-1:0] FIVE_E = EW'(5 * ONE_Q);
	localparam logic [2:0] SEC0 = 3'd0;
	localparam logic [2:0] SEC1 = 3'd1;
	localparam logic [2:0] SEC2 = 3'd2;
	localparam logic [2:0] SEC3 = 3'd3;
	localparam logic [2:0] SEC4 = 3'd4;
	localparam logic [2:0] SEC5 = 3'd5;

	logic adv;
	logic [WRAP_STEPS:0] wrap_v_s;
	logic [WRAP_W-1:0] wrap_rem_s [0:WRAP_STEPS];
	in_item_t wrap_item_s [0:WRAP_STEPS];
	logic v_s1, v_s2, v_s3;
	in_item_t item_s1, item_s2;
	logic signed [31:0] wa_s1, wa_s2;
	logic [2:0] sec_s1, sec_s2;
	logic signed [63:0] kp_s2;
	cmd_t cmd_s3;

	logic [WRAP_W-1:0] entry_rem;
	logic signed [31:0] wa_c;
	logic [2:0] sec_c;
	logic signed [63:0] k_full;
	logic signed [EW-1:0] k_c;
	logic signed [EW-1:0] e0_c, e1_c, e2_c;

	// the whole front advances together; it holds while its last item waits
	assign adv = !v_s3 || cmd_ready;
	assign full = !adv;
	assign cmd_valid = v_s3;
	assign cmd = cmd_s3;

	// lift the angle by pi plus a multiple of two pi so it is never negative
	assign entry_rem = {{(WRAP_W-32){in_item.rotor_angle[31]}}, in_item.rotor_angle} + WRAP_ADD;

	// wrapped angle and sector
	always_comb begin
		wa_c = 32'(wrap_rem_s[WRAP_STEPS]) - PI_S;
		if (wa_c < -PI23_S) begin
			sec_c = SEC0;
		end else if (wa_c < -PI3_S) begin
			sec_c = SEC1;
		end else if (wa_c < 32'sd0) begin
			sec_c = SEC2;
		end else if (wa_c < PI3_S) begin
			sec_c = SEC3;
		end else if (wa_c < PI23_S) begin
			sec_c = SEC4;
		end else begin
			sec_c = SEC5;
		end
	end

	// trapezoidal back-EMF shapes from the scaled angle
	always_comb begin
		k_full = rnd(kp_s2);
		k_c = k_full[EW-1:0];
		case (sec_s2)
			SEC0: begin
				e0_c = ONE_E; e1_c = k_c + FIVE_E; e2_c = -ONE_E;
			end
			SEC1: begin
				e0_c = -k_c - THREE_E; e1_c = ONE_E; e2_c = -ONE_E;
			end
			SEC2: begin
				e0_c = -ONE_E; e1_c = ONE_E; e2_c = k_c + ONE_E;
			end
			SEC3: begin
				e0_c = -ONE_E; e1_c = -k_c + ONE_E; e2_c = ONE_E;
			end
			SEC4: begin
				e0_c = k_c - THREE_E; e1_c = -ONE_E; e2_c = ONE_E;
			end
			default: begin
				e0_c = ONE_E; e1_c = -ONE_E; e2_c = -k_c + FIVE_E;
			end
		endcase
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_v_s <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			wrap_v_s <= {wrap_v_s[WRAP_STEPS-1:0], push};
			v_s1 <= wrap_v_s[WRAP_STEPS];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// advance payload: one conditional subtract per wrap stage
	always_ff @(posedge clk) begin
		if (adv) begin
			wrap_rem_s[0] <= entry_rem;
			wrap_item_s[0] <= in_item;
			for (int j = 1; j <= WRAP_STEPS; j++) begin
				if (wrap_rem_s[j-1] >= wrap_sub(WRAP_STEPS - j)) begin
					wrap_rem_s[j] <= wrap_rem_s[j-1] - wrap_sub(WRAP_STEPS - j);
				end else begin
					wrap_rem_s[j] <= wrap_rem_s[j-1];
				end
				wrap_item_s[j] <= wrap_item_s[j-1];
			end
			item_s1 <= wrap_item_s[WRAP_STEPS];
			wa_s1 <= wa_c;
			sec_s1 <= sec_c;
			item_s2 <= item_s1;
			wa_s2 <= wa_s1;
			sec_s2 <= sec_s1;
			kp_s2 <= K6_S * wa_s1;
			cmd_s3.item <= item_s2;
			cmd_s3.sector <= sec_s2;
			cmd_s3.wrapped_angle <= wa_s2;
			cmd_s3.e0 <= e0_c;
			cmd_s3.e1 <= e1_c;
			cmd_s3.e2 <= e2_c;
		end
	end

endmodule
`default_nettype wire

@@ rtl/bmd_queue.sv @@
// Short queue of classified items between the front and back pipelines.
`default_nettype none
module bmd_queue import bmd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	output logic      wr_ready,
	input  cmd_t      wr_data,
	output logic      rd_valid,
	input  wire logic rd_en,
	output cmd_t      rd_data
);

	cmd_t mem_q [0:QUEUE_DEPTH-1];
	logic [QA_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QA_W:0] count_q;
	logic do_wr, do_rd;

	assign wr_ready = count_q != (QA_W+1)'(QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr = wr_en && wr_ready;
	assign do_rd = rd_en && rd_valid;

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + QA_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QA_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (QA_W+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (QA_W+1)'(1);
			end
		end
	end

	// store the item
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

@@ rtl/bmd_back.sv @@
// Back pipeline: torque, current and speed derivatives with rounding and saturation.
`default_nettype none
module bmd_back import bmd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  cfg_t      cfg,
	input  wire logic cmd_valid,
	output logic      cmd_take,
	input  cmd_t      cmd,
	output logic      empty,
	input  wire logic pop,
	output out_item_t out_item
);

	typedef struct packed {
		logic signed [31:0] va;
		logic signed [31:0] vb;
		logic signed [31:0] vc;
		logic signed [31:0] tl;
		logic signed [31:0] w;
		logic [2:0]         sector;
		logic signed [31:0] wa;
	} pass_t;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	pass_t pass_s1, pass_s2, pass_s3, pass_s4, pass_s5, pass_s6, pass_s7;
	out_item_t out_s8;

	logic signed [31:0] rs_v, inv3l_v, flux_v, invj_v, fric_v;
	logic signed [7:0] poles_v;

	logic signed [63:0] pa_s1, pb_s1, pc_s1, rsa_s1, rsb_s1, fw_s1;
	logic signed [31:0] kq_s1;
	logic signed [EW+1:0] ca_s1, cb_s1, ca_s2, cb_s2, ca_s3, cb_s3;
	logic signed [31:0] s_s2;
	logic signed [63:0] emp_s2, rsa_s2, rsb_s2, fw_s2;
	logic signed [63:0] tp_s3, rsa_s3, rsb_s3, fw_s3;
	logic signed [31:0] em_s3;
	logic signed [47:0] t_s4;
	logic signed [63:0] ema_s4, emb_s4, rsa_s4, rsb_s4, fw_s4;
	logic signed [31:0] tq_s5, bra_s5, brb_s5;
	logic signed [63:0] fw_s5;
	logic signed [63:0] rap_s6, rbp_s6;
	logic signed [31:0] spsum_s6, tq_s6;
	logic signed [31:0] ra_s7, rb_s7, tq_s7;
	logic signed [63:0] spp_s7;

	logic signed [63:0] kqp_c, sum_c, t_c, tqp_c, bra_c, brb_c, spsum_c, rab_c;

	assign rs_v = {1'b0, cfg.rs};
	assign inv3l_v = {1'b0, cfg.inv3l};
	assign flux_v = {1'b0, cfg.flux};
	assign invj_v = {1'b0, cfg.invj};
	assign fric_v = {1'b0, cfg.fric};
	assign poles_v = {1'b0, cfg.poles};

	// the back advances together; it holds while the result waits
	assign adv = !v_s8 || pop;
	assign cmd_take = adv && cmd_valid;
	assign empty = !v_s8;
	assign out_item = out_s8;

	// pole-count products, rounding and bracket sums between the product stages
	always_comb begin
		kqp_c = flux_v * poles_v;
		sum_c = pa_s1 + pb_s1 + pc_s1;
		t_c = rnd(tp_s3);
		tqp_c = t_s4 * poles_v;
		bra_c = 64'sd2 * pass_s4.va - pass_s4.vb - pass_s4.vc - 64'sd3 * rsa_s4 + rnd(ema_s4);
		brb_c = 64'sd2 * pass_s4.vb - pass_s4.va - pass_s4.vc - 64'sd3 * rsb_s4 + rnd(emb_s4);
		spsum_c = 64'(tq_s5) - fw_s5 - 64'(pass_s5.tl);
		rab_c = 64'(ra_s7) + 64'(rb_s7);
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd_valid;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (adv) begin
			// phase products and per-item gains
			pass_s1.va <= cmd.item.voltage_a;
			pass_s1.vb <= cmd.item.voltage_b;
			pass_s1.vc <= cmd.item.voltage_c;
			pass_s1.tl <= cmd.item.load_torque;
			pass_s1.w <= cmd.item.rotor_speed;
			pass_s1.sector <= cmd.sector;
			pass_s1.wa <= cmd.wrapped_angle;
			pa_s1 <= cmd.e0 * cmd.item.current_a;
			pb_s1 <= cmd.e1 * cmd.item.current_b;
			pc_s1 <= cmd.e2 * cmd.item.current_c;
			rsa_s1 <= rs_v * cmd.item.current_a;
			rsb_s1 <= rs_v * cmd.item.current_b;
			fw_s1 <= fric_v * cmd.item.rotor_speed;
			kq_s1 <= sat32((kqp_c + 64'sd1) >>> 1);
			ca_s1 <= -(EW+2)'(2) * cmd.e0 + cmd.e1 + cmd.e2;
			cb_s1 <= cmd.e0 - (EW+2)'(2) * cmd.e1 + cmd.e2;

			// shape sum and emf gain times speed
			pass_s2 <= pass_s1;
			s_s2 <= sat32(rnd(sum_c));
			emp_s2 <= kq_s1 * pass_s1.w;
			rsa_s2 <= rnd(rsa_s1);
			rsb_s2 <= rnd(rsb_s1);
			fw_s2 <= rnd(fw_s1);
			ca_s2 <= ca_s1;
			cb_s2 <= cb_s1;

			// flux times shape sum, emf term
			pass_s3 <= pass_s2;
			tp_s3 <= flux_v * s_s2;
			em_s3 <= sat32(rnd(emp_s2));
			rsa_s3 <= rsa_s2;
			rsb_s3 <= rsb_s2;
			fw_s3 <= fw_s2;
			ca_s3 <= ca_s2;
			cb_s3 <= cb_s2;

			// emf term per phase
			pass_s4 <= pass_s3;
			t_s4 <= t_c[47:0];
			ema_s4 <= em_s3 * ca_s3;
			emb_s4 <= em_s3 * cb_s3;
			rsa_s4 <= rsa_s3;
			rsb_s4 <= rsb_s3;
			fw_s4 <= fw_s3;

			// torque and voltage brackets
			pass_s5 <= pass_s4;
			tq_s5 <= sat32((tqp_c + 64'sd1) >>> 1);
			bra_s5 <= sat32(bra_c);
			brb_s5 <= sat32(brb_c);
			fw_s5 <= fw_s4;

			// scale by inductance, net torque
			pass_s6 <= pass_s5;
			rap_s6 <= inv3l_v * bra_s5;
			rbp_s6 <= inv3l_v * brb_s5;
			spsum_s6 <= sat32(spsum_c);
			tq_s6 <= tq_s5;

			// current rates, scale by inertia
			pass_s7 <= pass_s6;
			ra_s7 <= sat32(rnd(rap_s6));
			rb_s7 <= sat32(rnd(rbp_s6));
			spp_s7 <= invj_v * spsum_s6;
			tq_s7 <= tq_s6;

			// result register
			out_s8.current_a_rate <= ra_s7;
			out_s8.current_b_rate <= rb_s7;
			out_s8.current_c_rate <= sat32(-rab_c);
			out_s8.speed_rate <= sat32(rnd(spp_s7));
			out_s8.angle_rate <= pass_s7.w;
			out_s8.motor_torque <= tq_s7;
			out_s8.sector <= pass_s7.sector;
			out_s8.wrapped_angle <= pass_s7.wa;
		end
	end

endmodule
`default_nettype wire

@@ rtl/bldc_motor_derivative_step.sv @@
// Top level of the BLDC motor derivative step.
//
// Items enter on a queue-style port: an item is taken at a clock edge with push high
// and full low. Results leave the same way: while empty is low the oldest result is on
// out_item and it is taken at an edge with pop high. One result per item, in order.
// The six model registers are written through cfg_we/cfg_addr/cfg_wdata; the user must write
// them only while no item is in flight, which the block does not enforce; unknown indexes are dropped.
// Throughput: one item per clock while pop keeps up. The path holds WRAP_STEPS + 13
// register stages, 27 at 16 fraction bits. The front has an entry stage plus WRAP_STEPS
// stages reducing the angle modulo two pi (one conditional subtract each), then three
// stages for sector, scaled angle and shapes; the mid queue adds one stage; the back
// has eight stages for the chained multiplies.
// When pop stays low the back holds, the four-entry mid queue fills, then the front
// holds and full rises; no item is dropped.
// Reset empties both pipelines and the queue and loads the default register values.
`default_nettype none
module bldc_motor_derivative_step import bmd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_AW-1:0] cfg_addr,
	input  wire logic [CFG_DW-1:0] cfg_wdata,
	input  wire logic              push,
	output logic                   full,
	input  in_item_t               in_item,
	output logic                   empty,
	input  wire logic              pop,
	output out_item_t              out_item
);

	cfg_t cfg;
	logic f_valid, q_ready, q_valid, q_take;
	cmd_t f_cmd, q_cmd;

	bmd_cfg_regs u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata), .cfg(cfg)
	);

	bmd_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.cmd_valid(f_valid), .cmd_ready(q_ready), .cmd(f_cmd)
	);

	bmd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_en(f_valid), .wr_ready(q_ready),
		.wr_data(f_cmd), .rd_valid(q_valid), .rd_en(q_take), .rd_data(q_cmd)
	);

	bmd_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .cmd_valid(q_valid), .cmd_take(q_take),
		.cmd(q_cmd), .empty(empty), .pop(pop), .out_item(out_item)
	);

	// front stalls only behind a full mid queue
	assert property (@(posedge clk) disable iff (!arst_n) full |-> !q_ready)
		else $error("front stalled with room in the mid queue");

	// results carry a sector in range
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> out_item.sector <= 3'd5)
		else $error("sector out of range");

	// wrapped angle lies in [-pi, pi)
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (out_item.wrapped_angle >= NEG_PI_S) && (out_item.wrapped_angle < PI_S))
		else $error("wrapped angle out of range");

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the BLDC motor derivative step block.
`default_nettype none
module testbench import bmd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_AW-1:0] CFG_UNUSED_A = 3'd6;
	localparam logic [CFG_AW-1:0] CFG_UNUSED_B = 3'd7;
	localparam int DRAIN_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [CFG_DW-1:0] cfg_wdata = '0;
	logic push = 1'b0;
	logic full;
	in_item_t in_item = '0;
	logic empty;
	logic pop = 1'b0;
	out_item_t out_item;

	// shadow copy of the model registers
	longint rs_c, inv3l_c, flux_c, poles_c, invj_c, fric_c;

	out_item_t rate_q[$];
	int errors = 0;
	int results_seen = 0;
	int items_sent = 0;
	int cfg_writes = 0;
	bit idle_on = 1'b1;
	int stall_req = 0;
	int hold_cnt = 0;
	int pop_wait = 0;

	bldc_motor_derivative_step u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata), .push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item)
	);

	always #10 clk = ~clk;

	function automatic int draw_gap();
		return idle_on ? $urandom_range(0, 6) : 0;
	endfunction

	// clamp to the signed 32-bit range
	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// round to nearest at shift s, ties up
	function automatic longint round_sh(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	// compute the expected derivatives of one item
	function automatic out_item_t derive_rates(in_item_t it);
		out_item_t o;
		longint ia, ib, ic, w, ang, va, vb, vc, tl;
		longint r, wa, k, e0, e1, e2, s, t, kq, em, bra, brb, ra, rb, tq, sp;
		logic [2:0] sec;
		ia = it.current_a; ib = it.current_b; ic = it.current_c;
		w = it.rotor_speed; ang = it.rotor_angle;
		va = it.voltage_a; vb = it.voltage_b; vc = it.voltage_c;
		tl = it.load_torque;
		r = (ang + PI_Q) % TWO_PI_Q;
		if (r < 0) r += TWO_PI_Q;
		wa = r - PI_Q;
		if (wa < -PI23_Q) sec = 3'd0;
		else if (wa < -PI3_Q) sec = 3'd1;
		else if (wa < 0) sec = 3'd2;
		else if (wa < PI3_Q) sec = 3'd3;
		else if (wa < PI23_Q) sec = 3'd4;
		else sec = 3'd5;
		k = round_sh(K6_Q * wa, FRAC_BITS);
		case (sec)
			3'd0: begin e0 = ONE_Q; e1 = k + 5 * ONE_Q; e2 = -ONE_Q; end
			3'd1: begin e0 = -k - 3 * ONE_Q; e1 = ONE_Q; e2 = -ONE_Q; end
			3'd2: begin e0 = -ONE_Q; e1 = ONE_Q; e2 = k + ONE_Q; end
			3'd3: begin e0 = -ONE_Q; e1 = -k + ONE_Q; e2 = ONE_Q; end
			3'd4: begin e0 = k - 3 * ONE_Q; e1 = -ONE_Q; e2 = ONE_Q; end
			default: begin e0 = ONE_Q; e1 = -ONE_Q; e2 = -k + 5 * ONE_Q; end
		endcase
		s = clamp32(round_sh(e0 * ia + e1 * ib + e2 * ic, FRAC_BITS));
		t = round_sh(flux_c * s, FRAC_BITS);
		tq = clamp32(round_sh(t * poles_c, 1));
		kq = clamp32(round_sh(flux_c * poles_c, 1));
		em = clamp32(round_sh(kq * w, FRAC_BITS));
		bra = 2 * va - vb - vc - 3 * round_sh(rs_c * ia, FRAC_BITS)
			+ round_sh(em * (-2 * e0 + e1 + e2), FRAC_BITS);
		brb = -va + 2 * vb - vc - 3 * round_sh(rs_c * ib, FRAC_BITS)
			+ round_sh(em * (e0 - 2 * e1 + e2), FRAC_BITS);
		ra = clamp32(round_sh(inv3l_c * clamp32(bra), FRAC_BITS));
		rb = clamp32(round_sh(inv3l_c * clamp32(brb), FRAC_BITS));
		sp = clamp32(tq - round_sh(fric_c * w, FRAC_BITS) - tl);
		sp = clamp32(round_sh(invj_c * sp, FRAC_BITS));
		o.current_a_rate = ra[31:0];
		o.current_b_rate = rb[31:0];
		o.current_c_rate = 32'(clamp32(-(ra + rb)));
		o.speed_rate = sp[31:0];
		o.angle_rate = it.rotor_speed;
		o.motor_torque = tq[31:0];
		o.sector = sec;
		o.wrapped_angle = wa[31:0];
		return o;
	endfunction

	// report one field mismatch
	task automatic check_field(string name, longint expv, longint actv);
		if (expv != actv) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $realtime, name, expv, actv);
		end
	endtask

	// compare every accepted result with the oldest expectation
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && pop && !empty) begin
			results_seen++;
			if (rate_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none actual %h", $realtime, out_item);
			end else begin
				e = rate_q.pop_front();
				check_field("current_a_rate", e.current_a_rate, out_item.current_a_rate);
				check_field("current_b_rate", e.current_b_rate, out_item.current_b_rate);
				check_field("current_c_rate", e.current_c_rate, out_item.current_c_rate);
				check_field("speed_rate", e.speed_rate, out_item.speed_rate);
				check_field("angle_rate", e.angle_rate, out_item.angle_rate);
				check_field("motor_torque", e.motor_torque, out_item.motor_torque);
				check_field("sector", e.sector, out_item.sector);
				check_field("wrapped_angle", e.wrapped_angle, out_item.wrapped_angle);
			end
		end
	end

	// drive pop: random waits per item, plus long holds on request
	always @(posedge clk) begin
		int g;
		if (arst_n) begin
			if (stall_req > 0) begin
				hold_cnt = stall_req;
				stall_req = 0;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				pop <= 1'b0;
			end else if (pop && !empty) begin
				g = draw_gap();
				pop_wait = g;
				pop <= (g == 0);
			end else if (pop_wait > 0) begin
				pop_wait--;
				pop <= (pop_wait == 0);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// offer one item until taken, then idle for a random gap
	task automatic send_item(in_item_t it);
		int g;
		push <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		rate_q.push_back(derive_rates(it));
		items_sent++;
		g = draw_gap();
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// wait until every expected result is back and the pipe is quiet
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (rate_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write one register while idle and track it in the shadow copy
	task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_writes++;
		case (idx)
			CFG_RS: rs_c = val;
			CFG_INV3L: inv3l_c = val;
			CFG_FLUX: flux_c = val;
			CFG_POLES: poles_c = val[6:0];
			CFG_INVJ: invj_c = val;
			CFG_FRIC: fric_c = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_all(logic [30:0] rs, logic [30:0] i3l, logic [30:0] fl,
			logic [30:0] p, logic [30:0] ij, logic [30:0] fr);
		write_reg(CFG_RS, rs);
		write_reg(CFG_INV3L, i3l);
		write_reg(CFG_FLUX, fl);
		write_reg(CFG_POLES, p);
		write_reg(CFG_INVJ, ij);
		write_reg(CFG_FRIC, fr);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
			2: return 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
			default: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
		endcase
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		it.current_a = rand_word();
		it.current_b = rand_word();
		it.current_c = rand_word();
		it.rotor_speed = rand_word();
		// angles near the wrap range most of the time
		it.rotor_angle = $urandom_range(0, 3) == 0 ? $urandom() :
			32'($signed($urandom_range(0, 16 * 65536)) - 8 * 65536);
		it.voltage_a = rand_word();
		it.voltage_b = rand_word();
		it.voltage_c = rand_word();
		it.load_torque = rand_word();
		return it;
	endfunction

	function automatic logic [30:0] rand_reg();
		case ($urandom_range(0, 3))
			0: return 31'($urandom());
			1: return 31'($urandom_range(0, 4 << 16));
			2: return 31'h7FFFFFFF;
			default: return 31'd0;
		endcase
	endfunction

	// extremes of the fields, sector edges, angle at exactly pi
	task automatic test_directed();
		in_item_t it;
		longint angles[14];
		angles = '{PI_Q, -PI_Q, 0, PI3_Q, -PI3_Q, PI23_Q, -PI23_Q, PI3_Q - 1,
			-PI23_Q - 1, TWO_PI_Q * 3 + 5, 2147483647, -2147483648, PI_Q - 1, -1};
		foreach (angles[i]) begin
			it = '{default: 32'sh00010000};
			it.rotor_angle = 32'(angles[i]);
			it.current_b = -32'sh00008000;
			send_item(it);
		end
		it = '{default: 32'sh7FFFFFFF};
		send_item(it);
		it = '{default: 32'sh80000000};
		send_item(it);
		it = '{default: 32'sh0};
		send_item(it);
		drain();
		// zero and odd pole counts together with the extremes of every register
		write_all(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'd0, 31'h7FFFFFFF, 31'h7FFFFFFF);
		repeat (3) send_item(rand_item());
		drain();
		write_all(31'd0, 31'd0, 31'd0, 31'd127, 31'd0, 31'd0);
		repeat (3) send_item(rand_item());
		drain();
		write_reg(CFG_POLES, 31'd3);
		write_reg(CFG_UNUSED_A, 31'h7FFFFFFF);
		write_reg(CFG_UNUSED_B, 31'h12345);
		write_all(31'h10000, 31'h8000, 31'h20000, 31'd3, 31'h10000, 31'h100);
		repeat (3) send_item(rand_item());
		drain();
	endtask

	// random items across several register settings
	task automatic test_random();
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 5) write_all(31'h10000, 31'h10000, 31'h10000, 31'd64, 31'h10000, 31'd0);
			else write_all(rand_reg(), rand_reg(), rand_reg(), 31'($urandom_range(0, 127)),
				rand_reg(), rand_reg());
			idle_on = (ph != 2);
			repeat (260) send_item(rand_item());
			idle_on = 1'b1;
			drain();
		end
	endtask

	// hold off the receiver long enough that the input stalls
	task automatic test_backpressure();
		idle_on = 1'b0;
		stall_req = 300;
		repeat (60) send_item(rand_item());
		idle_on = 1'b1;
		drain();
	endtask

	// sender pauses until all results are back, then resumes
	task automatic test_pause_resume();
		repeat (80) send_item(rand_item());
		push <= 1'b0;
		@(posedge clk);
		while (rate_q.size() != 0) @(posedge clk);
		repeat (80) send_item(rand_item());
		drain();
	endtask

	initial begin
		rs_c = ONE_Q; inv3l_c = ONE_Q; flux_c = ONE_Q;
		poles_c = 4; invj_c = ONE_Q; fric_c = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		test_pause_resume();
		$display("Covered %0d items, %0d results, %0d register writes,", items_sent,
			results_seen, cfg_writes);
		$display("sector edges, angle wrap, saturation, back-pressure and idle gaps.");
		if (errors == 0 && rate_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d results outstanding", errors, rate_q.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// end the run if it hangs
	initial begin
		#20ms;
		$display("timeout with %0d results outstanding", rate_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire

@@ files.f @@
rtl/bmd_pkg.sv
rtl/bmd_cfg_regs.sv
rtl/bmd_front.sv
rtl/bmd_queue.sv
rtl/bmd_back.sv
rtl/bldc_motor_derivative_step.sv
tb/testbench.sv
